[hdl/rmlm_pkg.sv]
// Package for the recursive mutex lock manager: sizes, request and status codes.
// No dependencies.
package rmlm_pkg;
  localparam int NumMutexes = 16;
  localparam int NumTasks   = 16;
  localparam int CountWidth = 8;
  localparam int MIdxW      = $clog2(NumMutexes);
  localparam int TIdxW      = $clog2(NumTasks);
  // mutex record: exists, held, owner, depth, nonempty, head, tail
  localparam int RecW       = 3 + TIdxW + CountWidth + 2 * TIdxW;

  localparam logic [1:0] ReqCreate = 2'd0;
  localparam logic [1:0] ReqDelete = 2'd1;
  localparam logic [1:0] ReqLock   = 2'd2;
  localparam logic [1:0] ReqUnlock = 2'd3;

  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StBadId    = 4'd1;
  localparam logic [3:0] StNotExist = 4'd2;
  localparam logic [3:0] StNoFree   = 4'd3;
  localparam logic [3:0] StBusy     = 4'd4;
  localparam logic [3:0] StQueued   = 4'd5;
  localparam logic [3:0] StNotOwner = 4'd6;
  localparam logic [3:0] StOverflow = 4'd7;
  localparam logic [3:0] StReleased = 4'd8;

  typedef struct packed {
    logic                  exists;
    logic                  held;
    logic [TIdxW-1:0]      owner;
    logic [CountWidth-1:0] depth;
    logic                  nonempty;
    logic [TIdxW-1:0]      head;
    logic [TIdxW-1:0]      tail;
  } mutex_rec_t;

  typedef struct packed {
    logic [3:0] status;
    logic [4:0] mutex_id;
    logic [3:0] task_id;
    logic       task_valid;
    logic       last;
  } result_t;
endpackage

[hdl/rmlm_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rmlm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/recursive_mutex_lock_manager.sv]
// Top level of the recursive mutex lock manager: sequencer around the mutex table,
// wait link and free-id memories. Depends on rmlm_pkg and rmlm_ram.
//
// Usage: requests enter on s_axis (tdata: req_type, mutex_id, task_id, poll_only).
// Results leave on m_axis (tdata: status, mutex_id_out, task_out, task_out_valid;
// tlast marks the final result of a request). The max_mutexes register is written
// on the cfg channel while idle; the user must keep to this, as the block does not
// enforce it. One request is handled at a time: the mutex record is read, decided
// and written back, and the result loaded into the output register; the next
// request is taken only once that result has been taken. An unlock that hands
// over to a waiter first reads the wait-link memory for the next head. A delete of
// a mutex with n waiters walks the wait-link memory, one waiter at a time, giving
// n+1 results; the final one is loaded when the last waiter's item is taken.
// The output register holds a result while m_axis_tready is low; the sequencer
// waits there and accepts nothing new until it is taken.
// Reset clears the control state and the per-mutex record valid bits; the memories
// themselves need no clearing pass.
module recursive_mutex_lock_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // req_type[1:0], mutex_id[6:2], task_id[10:7], poll_only[11]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[3:0], mutex_id_out[8:4], task_out[12:9], valid[13]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);
  localparam int MW = rmlm_pkg::MIdxW;
  localparam int TW = rmlm_pkg::TIdxW;
  localparam int CW = rmlm_pkg::CountWidth;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SExec  = 3'd2;
  localparam logic [2:0] SWalk  = 3'd3;
  localparam logic [2:0] SWalkR = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [4:0] max_q;
  logic [1:0] req_q;
  logic [4:0] id_q;
  logic [3:0] task_q;
  logic       poll_q;
  logic [MW:0] next_q;
  logic [MW-1:0] fhead_q;
  logic [MW:0]   fcount_q;
  logic [rmlm_pkg::NumMutexes-1:0] rec_vld_q;
  logic [rmlm_pkg::NumTasks-1:0]   twait_q;
  logic [TW-1:0] walk_q;
  logic [TW-1:0] wtail_q;
  logic after_walk_q;

  rmlm_pkg::result_t res_q;
  logic out_vld_q;

  // memories
  localparam int RecW_c = rmlm_pkg::RecW;
  logic rec_we, link_we, free_we;
  logic [MW-1:0] rec_waddr, rec_raddr, free_waddr, free_raddr;
  logic [RecW_c-1:0] rec_wdata, rec_rdata;
  logic [TW-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
  logic [MW-1:0] free_wdata, free_rdata;

  rmlm_ram #(.Width(RecW_c), .Depth(rmlm_pkg::NumMutexes)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata));
  rmlm_ram #(.Width(TW), .Depth(rmlm_pkg::NumTasks)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(link_raddr), .rdata_o(link_rdata));
  rmlm_ram #(.Width(MW), .Depth(rmlm_pkg::NumMutexes)) u_free (
    .clk_i, .we_i(free_we), .waddr_i(free_waddr), .wdata_i(free_wdata),
    .raddr_i(free_raddr), .rdata_o(free_rdata));

  logic [4:0] limit;
  assign limit = (max_q < 5'(rmlm_pkg::NumMutexes)) ? max_q : 5'(rmlm_pkg::NumMutexes);

  logic [MW-1:0] m_idx;
  assign m_idx = MW'(id_q - 5'd1);

  logic create_new;
  assign create_new = (5'(next_q) < limit);

  // slot handed out by create: next fresh id, else head of the free list
  logic [MW-1:0] new_idx;
  assign new_idx = create_new ? next_q[MW-1:0] : free_rdata;

  rmlm_pkg::mutex_rec_t rec, nrec;
  always_comb begin
    rec = rec_rdata;
    if (!rec_vld_q[m_idx]) rec = '0;
  end

  assign s_axis_tready = (state_q == SIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q.task_valid, res_q.task_id, res_q.mutex_id, res_q.status};
  assign m_axis_tlast  = res_q.last;

  assign rec_raddr  = (state_q == SIdle) ? MW'(s_axis_tdata[6:2] - 5'd1) : m_idx;
  assign rec_waddr  = (req_q == rmlm_pkg::ReqCreate) ? new_idx : m_idx;
  assign free_raddr = fhead_q;
  assign free_waddr = MW'(fhead_q + fcount_q[MW-1:0]);
  assign link_raddr = walk_q;

  logic ok_id;
  assign ok_id = (id_q != 5'd0) && (id_q <= limit);

  rmlm_pkg::result_t res_d;
  logic load_res;

  always_comb begin
    state_d    = state_q;
    rec_we     = 1'b0;
    rec_wdata  = '0;
    nrec       = rec;
    link_we    = 1'b0;
    link_waddr = rec.tail;
    link_wdata = task_q;
    free_we    = 1'b0;
    free_wdata = m_idx;
    load_res   = 1'b0;
    res_d      = '{status: rmlm_pkg::StOk, mutex_id: id_q, task_id: 4'd0,
                   task_valid: 1'b0, last: 1'b1};
    case (state_q)
      SIdle: if (s_axis_tvalid) state_d = SRead;
      SRead: state_d = SExec;
      SExec: begin
        load_res = 1'b1;
        state_d  = SOut;
        if (req_q == rmlm_pkg::ReqCreate) begin
          if (create_new || fcount_q != '0) begin
            res_d.mutex_id = 5'(new_idx) + 5'd1;
            nrec = '0;
            nrec.exists = 1'b1;
            rec_we = 1'b1;
            rec_wdata = nrec;
          end else begin
            res_d.status = rmlm_pkg::StNoFree;
            res_d.mutex_id = 5'd0;
          end
        end else if (!ok_id) begin
          res_d.status = rmlm_pkg::StBadId;
        end else if (!rec.exists) begin
          res_d.status = rmlm_pkg::StNotExist;
        end else if (req_q == rmlm_pkg::ReqDelete) begin
          if (rec.nonempty) begin
            load_res = 1'b0;
            state_d  = SWalkR;
          end else begin
            rec_we = 1'b1;
            nrec   = '0;
            rec_wdata = nrec;
            free_we = (fcount_q <= (MW+1)'(rmlm_pkg::NumMutexes - 1));
          end
        end else if (req_q == rmlm_pkg::ReqLock) begin
          if (!rec.held) begin
            nrec.held = 1'b1; nrec.owner = TW'(task_q); nrec.depth = '0;
            rec_we = 1'b1;
          end else if (rec.owner == TW'(task_q)) begin
            if (rec.depth == {CW{1'b1}}) res_d.status = rmlm_pkg::StOverflow;
            else begin
              nrec.depth = rec.depth + 1'b1; rec_we = 1'b1;
            end
          end else if (poll_q || twait_q[TW'(task_q)]) begin
            res_d.status = rmlm_pkg::StBusy;
          end else begin
            link_we = rec.nonempty;
            if (!rec.nonempty) nrec.head = TW'(task_q);
            nrec.tail = TW'(task_q);
            nrec.nonempty = 1'b1;
            rec_we = 1'b1;
            res_d.status = rmlm_pkg::StQueued;
          end
          rec_wdata = nrec;
        end else begin
          if (!rec.held || rec.owner != TW'(task_q)) res_d.status = rmlm_pkg::StNotOwner;
          else if (rec.depth != '0) begin
            nrec.depth = rec.depth - 1'b1; rec_we = 1'b1;
          end else if (rec.nonempty) begin
            // hand over to oldest waiter; next head comes from the link read
            load_res = 1'b0;
            state_d  = SWalkR;
          end else begin
            nrec.held = 1'b0; rec_we = 1'b1;
          end
          rec_wdata = nrec;
        end
      end
      SWalkR: state_d = SWalk; // link memory read of walk_q
      SWalk: begin
        load_res = 1'b1;
        state_d  = SOut;
        res_d.task_id = 4'(walk_q);
        res_d.task_valid = 1'b1;
        if (req_q == rmlm_pkg::ReqDelete) begin
          res_d.status = rmlm_pkg::StReleased;
          res_d.last   = 1'b0;
        end else begin
          if (walk_q == wtail_q) nrec.nonempty = 1'b0;
          else nrec.head = link_rdata;
          nrec.owner = walk_q; nrec.depth = '0;
          rec_we = 1'b1;
          rec_wdata = nrec;
        end
      end
      SOut: if (m_axis_tready) begin
        if (after_walk_q) state_d = SWalkR;
        else if (req_q == rmlm_pkg::ReqDelete && res_q.status == rmlm_pkg::StReleased) begin
          // final result of a delete
          load_res = 1'b1;
          state_d  = SOut;
          rec_we = 1'b1;
          nrec = '0;
          rec_wdata = nrec;
          free_we = (fcount_q <= (MW+1)'(rmlm_pkg::NumMutexes - 1));
        end else state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; max_q <= 5'd16; next_q <= '0; fhead_q <= '0; fcount_q <= '0;
      rec_vld_q <= '0; twait_q <= '0; out_vld_q <= 1'b0; after_walk_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) max_q <= cfg_data_i;
      if (load_res) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      if (rec_we) rec_vld_q[rec_waddr] <= 1'b1;
      if (free_we) fcount_q <= fcount_q + 1'b1;
      if (state_q == SExec && req_q == rmlm_pkg::ReqCreate) begin
        if (create_new) next_q <= next_q + 1'b1;
        else if (fcount_q != '0) begin
          fhead_q <= fhead_q + 1'b1;
          fcount_q <= fcount_q - 1'b1;
        end
      end
      if (state_q == SExec && ok_id && rec.exists && req_q == rmlm_pkg::ReqLock &&
          rec.held && rec.owner != TW'(task_q) && !poll_q && !twait_q[TW'(task_q)])
        twait_q[TW'(task_q)] <= 1'b1;
      if (state_q == SExec) begin
        walk_q <= rec.head; wtail_q <= rec.tail;
      end
      if (state_q == SWalk) begin
        twait_q[walk_q] <= 1'b0;
        walk_q <= link_rdata;
        after_walk_q <= (req_q == rmlm_pkg::ReqDelete) && (walk_q != wtail_q);
      end else if (state_q == SOut && m_axis_tready) after_walk_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && s_axis_tvalid) begin
      req_q <= s_axis_tdata[1:0]; id_q <= s_axis_tdata[6:2];
      task_q <= s_axis_tdata[10:7]; poll_q <= s_axis_tdata[11];
    end
    if (load_res) res_q <= res_d;
  end
endmodule

[hdl/rmlm_checker.sv]
// Port-level checker for the recursive mutex lock manager, bound to the top level.
// Depends on the top-level ports only.
module rmlm_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_rel_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] == 4'd8 |-> !m_axis_tlast && m_axis_tdata[13])
    else $error("released item marked last");
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back-to-back accept");
endmodule

bind recursive_mutex_lock_manager rmlm_port_checker u_rmlm_checker (.*);
